>>> src/fcull_pkg.sv
// Shared types, constants and codes for the frustum cull test block.
package fcull_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int PLANE_COUNT_DEF = 6;
   localparam int IDX_WIDTH       = 3;
   localparam int FRAC_BITS       = 16;

   // |nx|+|ny|+|nz| needs two more bits than one coordinate
   localparam int ABS_W  = COORD_WIDTH + 2;
   localparam int OPA_W  = ABS_W + 1;
   localparam int PROD_W = OPA_W + COORD_WIDTH;
   localparam int ACC_W  = PROD_W;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_POINT = 2'd1;
   localparam logic [1:0] FUNC_CUBE  = 2'd2;

   // multiplier operand selection, one code per step of a plane
   localparam logic [1:0] STEP_X = 2'd0;
   localparam logic [1:0] STEP_Y = 2'd1;
   localparam logic [1:0] STEP_Z = 2'd2;
   localparam logic [1:0] STEP_R = 2'd3;

   typedef struct packed {
      logic [1:0]                    func;
      logic [IDX_WIDTH-1:0]          plane_index;
      logic signed [COORD_WIDTH-1:0] normal_x;
      logic signed [COORD_WIDTH-1:0] normal_y;
      logic signed [COORD_WIDTH-1:0] normal_z;
      logic signed [COORD_WIDTH-1:0] offset_in;
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
      logic [COORD_WIDTH-2:0]        half_size;
   } req_type;

   typedef struct packed {
      logic visible;
      logic was_cube;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] normal_x;
      logic signed [COORD_WIDTH-1:0] normal_y;
      logic signed [COORD_WIDTH-1:0] normal_z;
      logic signed [COORD_WIDTH-1:0] offset;
   } plane_type;

   typedef struct packed {
      logic       start;   // latch point, clear verdict
      logic       issue;   // multiply this cycle
      logic       first;   // first product of a plane
      logic       last;    // last product of a plane
      logic       finish;  // last product of the last plane
      logic [1:0] sel;     // operand step code
   } mac_ctrl_type;

   typedef struct packed {
      logic done;
      logic visible;
   } mac_stat_type;

endpackage

>>> src/frustum_cull_test_core.sv
// Top level of the frustum cull test block: plane store, sequencer and shared multiplier.
// Holds PLANE_COUNT planes (normal and offset, signed Q16.16) and answers point and cube
// visibility tests against all of them. A load item (func 0) writes one plane in the
// cycle it is accepted and gives no result; a plane index at or above PLANE_COUNT and
// func 3 are dropped silently. A point test (func 1) or cube test (func 2) gives one
// result item. All sums are exact; a sum of exactly zero counts as inside, and planes
// never loaded hold zero and always pass. Every plane is evaluated by one shared
// 35x32 signed multiplier, one product per cycle, with the product registered and
// accumulated the next cycle: a point test takes three products per plane, a cube test
// four (the x, y, z terms plus half size times |nx|+|ny|+|nz|, which is the largest
// corner). req_ready is low from the accepting edge until the test's result is loaded
// into the output register, and comes back in that same cycle, so a new item is taken
// only once the previous test is through. A finished result waits in the output
// register while the next item is accepted; a later test holds only when its own
// result is due and the earlier one is still untaken.
module frustum_cull_test_core import fcull_pkg::*; #(
   parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int PIDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

   mac_ctrl_type      ctrl;
   mac_stat_type      stat;
   plane_type         wr_plane, rd_plane;
   logic [PIDX_W-1:0] rd_idx;
   logic              load_en;

   always_comb begin
      // loads are taken only in idle, so the store never changes mid-test
      load_en           = req_valid && req_ready && (req_data.func == FUNC_LOAD);
      wr_plane.normal_x = req_data.normal_x;
      wr_plane.normal_y = req_data.normal_y;
      wr_plane.normal_z = req_data.normal_z;
      wr_plane.offset   = req_data.offset_in;
   end

   fcull_plane_store #(
      .PLANE_COUNT (PLANE_COUNT),
      .PIDX_W      (PIDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (load_en),
      .wr_idx  (req_data.plane_index),
      .wr_data (wr_plane),
      .rd_idx  (rd_idx),
      .rd_data (rd_plane)
   );

   fcull_seq #(
      .PLANE_COUNT (PLANE_COUNT),
      .PIDX_W      (PIDX_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .stat      (stat),
      .ctrl      (ctrl),
      .rd_idx    (rd_idx)
   );

   fcull_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .plane     (rd_plane),
      .point_x   (req_data.point_x),
      .point_y   (req_data.point_y),
      .point_z   (req_data.point_z),
      .half_size (req_data.half_size),
      .stat      (stat)
   );

endmodule

>>> src/fcull_plane_store.sv
// Plane register file: one write port for loads, one read port for the sequencer.
module fcull_plane_store import fcull_pkg::*; #(
   parameter int PLANE_COUNT = PLANE_COUNT_DEF,
   parameter int PIDX_W      = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [IDX_WIDTH-1:0] wr_idx,
   input  plane_type            wr_data,
   input  logic [PIDX_W-1:0]    rd_idx,
   output plane_type            rd_data
);

   plane_type         store_ff [PLANE_COUNT];
   logic              wr_hit;
   logic [PIDX_W-1:0] wr_slot;

   always_comb begin
      wr_hit  = wr_en && (int'(wr_idx) < PLANE_COUNT);
      wr_slot = PIDX_W'(wr_idx);
      rd_data = store_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLANE_COUNT; i++) begin
            store_ff[i] <= '0;
         end
      end else if (wr_hit) begin
         store_ff[wr_slot] <= wr_data;
      end
   end

endmodule

>>> src/fcull_mac.sv
// Shared signed multiplier with registered product and plane accumulator.
module fcull_mac import fcull_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  mac_ctrl_type                  ctrl,
   input  plane_type                     plane,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   input  logic signed [COORD_WIDTH-1:0] point_z,
   input  logic [COORD_WIDTH-2:0]        half_size,
   output mac_stat_type                  stat
);

   logic signed [COORD_WIDTH-1:0] px_ff, py_ff, pz_ff;
   logic [COORD_WIDTH-2:0]        r_ff;
   logic [ABS_W-1:0]              abs_sum_ff, abs_sum_in;
   logic signed [COORD_WIDTH-1:0] off_ff;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic                          prod_vld_ff, prod_first_ff, prod_last_ff, prod_finish_ff;
   logic signed [ACC_W-1:0]       acc_ff, acc_base, acc_in;
   logic                          vis_ff, done_ff;

   logic [COORD_WIDTH:0]          ext_x, ext_y, ext_z, mag_x, mag_y, mag_z;
   logic signed [OPA_W-1:0]       opa;
   logic signed [COORD_WIDTH-1:0] opb;

   always_comb begin
      ext_x = {plane.normal_x[COORD_WIDTH-1], plane.normal_x};
      ext_y = {plane.normal_y[COORD_WIDTH-1], plane.normal_y};
      ext_z = {plane.normal_z[COORD_WIDTH-1], plane.normal_z};
      mag_x = ext_x[COORD_WIDTH] ? (~ext_x + 1'b1) : ext_x;
      mag_y = ext_y[COORD_WIDTH] ? (~ext_y + 1'b1) : ext_y;
      mag_z = ext_z[COORD_WIDTH] ? (~ext_z + 1'b1) : ext_z;
      abs_sum_in = ABS_W'(mag_x) + ABS_W'(mag_y) + ABS_W'(mag_z);

      case (ctrl.sel)
         STEP_X: begin
            opa = {{(OPA_W-COORD_WIDTH){plane.normal_x[COORD_WIDTH-1]}}, plane.normal_x};
            opb = px_ff;
         end
         STEP_Y: begin
            opa = {{(OPA_W-COORD_WIDTH){plane.normal_y[COORD_WIDTH-1]}}, plane.normal_y};
            opb = py_ff;
         end
         STEP_Z: begin
            opa = {{(OPA_W-COORD_WIDTH){plane.normal_z[COORD_WIDTH-1]}}, plane.normal_z};
            opb = pz_ff;
         end
         default: begin
            // largest corner: half size times the sum of normal magnitudes
            opa = {{(OPA_W-ABS_W){1'b0}}, abs_sum_ff};
            opb = {1'b0, r_ff};
         end
      endcase
      prod_in = opa * opb;

      // offset in Q16.16 aligned to the Q35.32 products
      acc_base = prod_first_ff
               ? {{(ACC_W-COORD_WIDTH-FRAC_BITS){off_ff[COORD_WIDTH-1]}}, off_ff,
                  {FRAC_BITS{1'b0}}}
               : acc_ff;
      acc_in = acc_base + prod_ff;

      stat.done    = done_ff;
      stat.visible = vis_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         px_ff <= point_x;
         py_ff <= point_y;
         pz_ff <= point_z;
         r_ff  <= half_size;
      end
      if (ctrl.issue) begin
         prod_ff        <= prod_in;
         prod_first_ff  <= ctrl.first;
         prod_last_ff   <= ctrl.last;
         prod_finish_ff <= ctrl.finish;
         if (ctrl.sel == STEP_X) begin
            abs_sum_ff <= abs_sum_in;
            off_ff     <= plane.offset;
         end
      end
      if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         vis_ff      <= 1'b1;
         done_ff     <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.issue;
         if (ctrl.start) begin
            vis_ff  <= 1'b1;
            done_ff <= 1'b0;
         end else if (prod_vld_ff) begin
            if (prod_last_ff && acc_in[ACC_W-1]) begin
               vis_ff <= 1'b0;
            end
            if (prod_finish_ff) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

>>> src/fcull_seq.sv
// Sequencer: walks planes and multiplier steps, owns the result register.
module fcull_seq import fcull_pkg::*; #(
   parameter int PLANE_COUNT = PLANE_COUNT_DEF,
   parameter int PIDX_W      = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_func,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  mac_stat_type      stat,
   output mac_ctrl_type      ctrl,
   output logic [PIDX_W-1:0] rd_idx
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_RUN   = 3'b010,
      S_DRAIN = 3'b100
   } seq_state_type;

   seq_state_type     state_ff, state_in;
   logic [PIDX_W-1:0] plane_ff, plane_in;
   logic [1:0]        step_ff, step_in;
   logic              cube_ff, cube_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;
   logic              test_acc, step_last, plane_last, rsp_load;
   logic [1:0]        last_step;

   always_comb begin
      req_ready  = (state_ff == S_IDLE);
      test_acc   = req_valid && req_ready
                && (req_func == FUNC_POINT || req_func == FUNC_CUBE);
      last_step  = cube_ff ? STEP_R : STEP_Z;
      step_last  = (step_ff == last_step);
      plane_last = (plane_ff == PIDX_W'(PLANE_COUNT - 1));

      ctrl.start  = test_acc;
      ctrl.issue  = (state_ff == S_RUN);
      ctrl.first  = (step_ff == STEP_X);
      ctrl.last   = step_last;
      ctrl.finish = step_last && plane_last;
      ctrl.sel    = step_ff;
      rd_idx      = plane_ff;

      rsp_load = (state_ff == S_DRAIN) && stat.done && (!rsp_valid_ff || rsp_ready);

      state_in = state_ff;
      plane_in = plane_ff;
      step_in  = step_ff;
      cube_in  = cube_ff;
      case (state_ff)
         S_IDLE: begin
            if (test_acc) begin
               state_in = S_RUN;
               plane_in = '0;
               step_in  = STEP_X;
               cube_in  = (req_func == FUNC_CUBE);
            end
         end
         S_RUN: begin
            if (step_last) begin
               step_in = STEP_X;
               if (plane_last) begin
                  // wrap so the read index never leaves the store
                  plane_in = '0;
                  state_in = S_DRAIN;
               end else begin
                  plane_in = plane_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         S_DRAIN: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         plane_ff     <= '0;
         step_ff      <= STEP_X;
         cube_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plane_ff     <= plane_in;
         step_ff      <= step_in;
         cube_ff      <= cube_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.visible  <= stat.visible;
         rsp_data_ff.was_cube <= cube_ff;
      end
   end

endmodule

>>> src/fcull_checker.sv
// Port-level checks for the frustum cull test block, bound to the top level.
module fcull_checker import fcull_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic test_acc, load_acc;

   always_comb begin
      test_acc = req_valid && req_ready
              && (req_data.func == FUNC_POINT || req_data.func == FUNC_CUBE);
      load_acc = req_valid && req_ready && (req_data.func == FUNC_LOAD);
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // a test occupies the block
   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      test_acc |=> !req_ready)
      else $error("ready after accepting a test item");

   // a test never answers in the next cycle
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      test_acc && !rsp_valid |=> !rsp_valid)
      else $error("result appeared one cycle after a test item");

   // a load finishes in the cycle it is taken
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      load_acc |=> req_ready)
      else $error("load item left the block busy");

   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind frustum_cull_test_core fcull_checker u_checker (.*);
